[hdl/rotating_point_velocity_defines.svh]
// ---------------------------------------------------------------------------
// rotating_point_velocity assertion macros
// Shared concurrent assertion forms for the rotating point velocity block.
// ---------------------------------------------------------------------------
`ifndef ROTATING_POINT_VELOCITY_DEFINES_SVH
`define ROTATING_POINT_VELOCITY_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RPV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define RPV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/rpv_pkg.sv]
// ---------------------------------------------------------------------------
// rpv_pkg
// Types, constants and helpers of the rotating point velocity block.
// ---------------------------------------------------------------------------
package rpv_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 16;
   localparam int GUARD_BITS    = 6;

   localparam int CFG_W      = 24;
   localparam int TIME_W     = 32;
   localparam int VEL_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int D_W        = CFG_W + 1;
   localparam int P_W        = CFG_W + TIME_W;
   localparam int WIDE_W     = 64;

   // angle in radians, only the bits that reach the turn fraction are kept
   localparam int ANG_FULL_W = P_W - FRAC_BITS;
   localparam int ANG_W      = (ANG_FULL_W < FRAC_BITS + 32) ? ANG_FULL_W : FRAC_BITS + 32;
   localparam int ANG_LO_W   = ANG_W / 2;
   localparam int ANG_HI_W   = ANG_W - ANG_LO_W;

   localparam int K_W = 30;
   localparam logic [K_W-1:0] INV_TWO_PI_Q32 = K_W'(683565276);
   localparam int PP_LO_W = ANG_LO_W + K_W;
   localparam int PP_HI_W = ANG_HI_W + K_W + 1;

   localparam int THETA_W = 32;
   localparam int Z_W     = 32;
   localparam int XY_W    = 33;

   localparam int GAIN_W     = 31;
   localparam logic signed [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032874);
   localparam int GAIN_SHIFT = 30 + GUARD_BITS;
   localparam int GPROD_W    = XY_W + GAIN_W;
   localparam int R_W        = 28;
   localparam int PV_W       = CFG_W + R_W;

   localparam int STAGE_IDX_W = 5;

   localparam logic [THETA_W-1:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X  = 3'd0,
      CSR_CENTER_Y  = 3'd1,
      CSR_CENTER_Z  = 3'd2,
      CSR_PUSH_X    = 3'd3,
      CSR_PUSH_Y    = 3'd4,
      CSR_PUSH_Z    = 3'd5,
      CSR_SPIN_RATE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] rate;
      logic signed [D_W-1:0]   dx;
      logic signed [D_W-1:0]   dy;
   } cfg_type;

   typedef struct packed {
      logic                   ok;
      quad_type               quad;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_data_type;

   function automatic logic [STAGE_IDX_W-1:0] stage_index(input int i);
      stage_index = i[STAGE_IDX_W-1:0];
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'({1'b0, {(VEL_W-1){1'b1}}});
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         sat_vel = hi[VEL_W-1:0];
      end else if (v < lo) begin
         sat_vel = lo[VEL_W-1:0];
      end else begin
         sat_vel = v[VEL_W-1:0];
      end
   endfunction

endpackage

[hdl/rpv_front.sv]
// ---------------------------------------------------------------------------
// rpv_front
// Angle pipeline: rate * time, turn fraction, quarter split, CORDIC seed.
// ---------------------------------------------------------------------------
module rpv_front (
   input  logic                           clock,
   input  logic                           reset,
   input  rpv_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [rpv_pkg::TIME_W-1:0] req_time_s,
   output logic                           out_valid,
   output rpv_pkg::cordic_data_type       out_data,
   input  logic                           out_hold
);

   // stage 1: product rate * time
   logic                                  v1_ff;
   logic                                  ok1_ff;
   logic signed [rpv_pkg::P_W-1:0]        p_ff;
   logic signed [rpv_pkg::P_W-1:0]        p_in;
   logic                                  hold1;

   // stage 2: partial products of angle * 1/(2 pi)
   logic                                  v2_ff;
   logic                                  ok2_ff;
   logic [rpv_pkg::PP_LO_W-1:0]           pp_lo_ff;
   logic signed [rpv_pkg::PP_HI_W-1:0]    pp_hi_ff;
   logic [rpv_pkg::PP_LO_W-1:0]           pp_lo_in;
   logic signed [rpv_pkg::PP_HI_W-1:0]    pp_hi_in;
   logic signed [rpv_pkg::P_W-1:0]        ang_full;
   logic [rpv_pkg::ANG_LO_W-1:0]          ang_lo;
   logic signed [rpv_pkg::ANG_HI_W-1:0]   ang_hi;
   logic                                  hold2;

   // stage 3: CORDIC seed
   logic                                  v3_ff;
   rpv_pkg::cordic_data_type              seed_ff;
   rpv_pkg::cordic_data_type              seed_in;
   logic [rpv_pkg::WIDE_W-1:0]            turn_sum;
   logic [rpv_pkg::THETA_W-1:0]           theta;
   logic [rpv_pkg::THETA_W-1:0]           theta_rnd;
   logic [rpv_pkg::THETA_W-1:0]           resid;
   logic                                  hold3;

   assign hold3     = v3_ff && out_hold;
   assign hold2     = v2_ff && hold3;
   assign hold1     = v1_ff && hold2;
   assign req_ready = !hold1;

   assign p_in = req_time_s * cfg.rate;

   always_comb begin
      ang_full = p_ff >>> rpv_pkg::FRAC_BITS;
      ang_lo   = ang_full[rpv_pkg::ANG_LO_W-1:0];
      ang_hi   = ang_full[rpv_pkg::ANG_W-1:rpv_pkg::ANG_LO_W];
      pp_lo_in = rpv_pkg::PP_LO_W'(ang_lo) * rpv_pkg::PP_LO_W'(rpv_pkg::INV_TWO_PI_Q32);
      pp_hi_in = ang_hi * $signed({1'b0, rpv_pkg::INV_TWO_PI_Q32});
   end

   // wrap of the 32-bit turn fraction modulo one turn is the reduction modulo 2 pi
   always_comb begin
      turn_sum  = rpv_pkg::WIDE_W'(pp_lo_ff)
                + (rpv_pkg::WIDE_W'(pp_hi_ff) << rpv_pkg::ANG_LO_W);
      theta     = turn_sum[rpv_pkg::FRAC_BITS+rpv_pkg::THETA_W-1:rpv_pkg::FRAC_BITS];
      theta_rnd = theta + rpv_pkg::THETA_W'(32'h2000_0000);
      resid     = theta - {theta_rnd[rpv_pkg::THETA_W-1:rpv_pkg::THETA_W-2],
                           {(rpv_pkg::THETA_W-2){1'b0}}};
      seed_in.ok   = ok2_ff;
      seed_in.quad = rpv_pkg::quad_type'(theta_rnd[rpv_pkg::THETA_W-1:rpv_pkg::THETA_W-2]);
      seed_in.x    = rpv_pkg::XY_W'(cfg.dx) <<< rpv_pkg::GUARD_BITS;
      seed_in.y    = rpv_pkg::XY_W'(cfg.dy) <<< rpv_pkg::GUARD_BITS;
      seed_in.z    = $signed(resid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (!hold1) begin
            v1_ff <= req_valid;
         end
         if (!hold2) begin
            v2_ff <= v1_ff;
         end
         if (!hold3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold1) begin
         p_ff   <= p_in;
         ok1_ff <= !req_time_s[rpv_pkg::TIME_W-1];
      end
      if (!hold2) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         ok2_ff   <= ok1_ff;
      end
      if (!hold3) begin
         seed_ff <= seed_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = seed_ff;

endmodule

[hdl/rpv_cordic_cell.sv]
// ---------------------------------------------------------------------------
// rpv_cordic_cell
// One CORDIC rotation step with its own stage register.
// ---------------------------------------------------------------------------
module rpv_cordic_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rpv_pkg::STAGE_IDX_W-1:0]     stage_idx,
   input  logic                                in_valid,
   input  rpv_pkg::cordic_data_type            in_data,
   output logic                                in_hold,
   output logic                                out_valid,
   output rpv_pkg::cordic_data_type            out_data,
   input  logic                                out_hold
);

   logic                                  valid_ff;
   rpv_pkg::cordic_data_type              data_ff;
   rpv_pkg::cordic_data_type              data_in;
   logic signed [rpv_pkg::XY_W-1:0]       x_shift;
   logic signed [rpv_pkg::XY_W-1:0]       y_shift;
   logic signed [rpv_pkg::Z_W-1:0]        atan_step;

   assign in_hold = valid_ff && out_hold;

   always_comb begin
      x_shift   = in_data.x >>> stage_idx;
      y_shift   = in_data.y >>> stage_idx;
      atan_step = $signed(rpv_pkg::ATAN_TURNS[stage_idx]);
      data_in   = in_data;
      // rotate toward zero residual angle
      if (!in_data.z[rpv_pkg::Z_W-1]) begin
         data_in.x = in_data.x - y_shift;
         data_in.y = in_data.y + x_shift;
         data_in.z = in_data.z - atan_step;
      end else begin
         data_in.x = in_data.x + y_shift;
         data_in.y = in_data.y - x_shift;
         data_in.z = in_data.z + atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_hold) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_hold) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hdl/rpv_back.sv]
// ---------------------------------------------------------------------------
// rpv_back
// Gain correction, quarter-turn restore, cross product and result register.
// ---------------------------------------------------------------------------
module rpv_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [rpv_pkg::CFG_W-1:0]    rate,
   input  logic                                in_valid,
   input  rpv_pkg::cordic_data_type            in_data,
   output logic                                in_hold,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rpv_pkg::VEL_W-1:0]    rsp_vel_x,
   output logic signed [rpv_pkg::VEL_W-1:0]    rsp_vel_y,
   output logic                                rsp_ok
);

   // stage 4: gain multiply
   logic                                  v4_ff;
   logic                                  ok4_ff;
   rpv_pkg::quad_type                     quad4_ff;
   logic signed [rpv_pkg::GPROD_W-1:0]    gx_ff;
   logic signed [rpv_pkg::GPROD_W-1:0]    gy_ff;
   logic signed [rpv_pkg::GPROD_W-1:0]    gx_in;
   logic signed [rpv_pkg::GPROD_W-1:0]    gy_in;
   logic                                  hold4;

   // stage 5: rounding and quarter turns
   logic                                  v5_ff;
   logic                                  ok5_ff;
   logic signed [rpv_pkg::R_W-1:0]        rx_ff;
   logic signed [rpv_pkg::R_W-1:0]        ry_ff;
   logic signed [rpv_pkg::R_W-1:0]        rx_in;
   logic signed [rpv_pkg::R_W-1:0]        ry_in;
   logic signed [rpv_pkg::GPROD_W-1:0]    gx_rnd;
   logic signed [rpv_pkg::GPROD_W-1:0]    gy_rnd;
   logic signed [rpv_pkg::R_W-1:0]        cx;
   logic signed [rpv_pkg::R_W-1:0]        cy;
   logic                                  hold5;

   // stage 6: rate products
   logic                                  v6_ff;
   logic                                  ok6_ff;
   logic signed [rpv_pkg::PV_W-1:0]       pvx_ff;
   logic signed [rpv_pkg::PV_W-1:0]       pvy_ff;
   logic                                  hold6;

   // stage 7: result register
   logic                                  v7_ff;
   logic                                  ok7_ff;
   logic signed [rpv_pkg::VEL_W-1:0]      vx_ff;
   logic signed [rpv_pkg::VEL_W-1:0]      vy_ff;
   logic signed [rpv_pkg::VEL_W-1:0]      vx_in;
   logic signed [rpv_pkg::VEL_W-1:0]      vy_in;
   logic signed [rpv_pkg::WIDE_W-1:0]     vx_wide;
   logic signed [rpv_pkg::WIDE_W-1:0]     vy_wide;
   logic signed [rpv_pkg::WIDE_W-1:0]     vel_rnd;
   logic                                  hold7;

   assign hold7   = v7_ff && !rsp_ready;
   assign hold6   = v6_ff && hold7;
   assign hold5   = v5_ff && hold6;
   assign hold4   = v4_ff && hold5;
   assign in_hold = hold4;

   assign gx_in = in_data.x * rpv_pkg::GAIN_Q30;
   assign gy_in = in_data.y * rpv_pkg::GAIN_Q30;

   always_comb begin
      gx_rnd = (gx_ff + (rpv_pkg::GPROD_W'(1) <<< (rpv_pkg::GAIN_SHIFT - 1)))
               >>> rpv_pkg::GAIN_SHIFT;
      gy_rnd = (gy_ff + (rpv_pkg::GPROD_W'(1) <<< (rpv_pkg::GAIN_SHIFT - 1)))
               >>> rpv_pkg::GAIN_SHIFT;
      cx = gx_rnd[rpv_pkg::R_W-1:0];
      cy = gy_rnd[rpv_pkg::R_W-1:0];
      case (quad4_ff)
         rpv_pkg::QUAD_0: begin
            rx_in = cx;
            ry_in = cy;
         end
         rpv_pkg::QUAD_90: begin
            rx_in = -cy;
            ry_in = cx;
         end
         rpv_pkg::QUAD_180: begin
            rx_in = -cx;
            ry_in = -cy;
         end
         rpv_pkg::QUAD_270: begin
            rx_in = cy;
            ry_in = -cx;
         end
         default: begin
            rx_in = cx;
            ry_in = cy;
         end
      endcase
   end

   // w x r: vel_x = -rate * ry, vel_y = rate * rx
   always_comb begin
      vel_rnd = rpv_pkg::WIDE_W'(1) <<< (rpv_pkg::FRAC_BITS - 1);
      vx_wide = (-rpv_pkg::WIDE_W'(pvx_ff) + vel_rnd) >>> rpv_pkg::FRAC_BITS;
      vy_wide = (rpv_pkg::WIDE_W'(pvy_ff) + vel_rnd) >>> rpv_pkg::FRAC_BITS;
      if (ok6_ff) begin
         vx_in = rpv_pkg::sat_vel(vx_wide);
         vy_in = rpv_pkg::sat_vel(vy_wide);
      end else begin
         vx_in = '0;
         vy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (!hold4) begin
            v4_ff <= in_valid;
         end
         if (!hold5) begin
            v5_ff <= v4_ff;
         end
         if (!hold6) begin
            v6_ff <= v5_ff;
         end
         if (!hold7) begin
            v7_ff <= v6_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold4) begin
         gx_ff    <= gx_in;
         gy_ff    <= gy_in;
         quad4_ff <= in_data.quad;
         ok4_ff   <= in_data.ok;
      end
      if (!hold5) begin
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         ok5_ff <= ok4_ff;
      end
      if (!hold6) begin
         pvx_ff <= rate * ry_ff;
         pvy_ff <= rate * rx_ff;
         ok6_ff <= ok5_ff;
      end
      if (!hold7) begin
         vx_ff  <= vx_in;
         vy_ff  <= vy_in;
         ok7_ff <= ok6_ff;
      end
   end

   assign rsp_valid = v7_ff;
   assign rsp_vel_x = vx_ff;
   assign rsp_vel_y = vy_ff;
   assign rsp_ok    = ok7_ff;

endmodule

[hdl/rotating_point_velocity.sv]
// ---------------------------------------------------------------------------
// rotating_point_velocity
// Velocity of a point on an object spinning about z, one result per sample.
// ---------------------------------------------------------------------------
// Fully pipelined: one time sample is taken every cycle while the result side
// does not stall, and every sample gives one result beat, in order. There are
// CORDIC_STAGES + 7 register stages (23 at 16 stages): three angle stages,
// one CORDIC cell per stage, then gain, quarter-turn, rate product and result
// register. Sustained rate is set by the result side only: a stalled result
// beat holds just the stages that are full, so empty stages still fill while
// the output waits, and the input ready follows the result ready through the
// stage chain in the same cycle. Negative times come out with ok low and zero
// velocity. Registers are written with csr_we; center_z and push_z have no
// effect and are not stored. Reprogram only when drained.
// ---------------------------------------------------------------------------
`include "rotating_point_velocity_defines.svh"

module rotating_point_velocity (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [rpv_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [rpv_pkg::CFG_W-1:0]              csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [rpv_pkg::TIME_W-1:0]      req_time_s,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rpv_pkg::VEL_W-1:0]       rsp_vel_x,
   output logic signed [rpv_pkg::VEL_W-1:0]       rsp_vel_y,
   output logic                                   rsp_ok
);

   logic signed [rpv_pkg::CFG_W-1:0]  center_x_ff;
   logic signed [rpv_pkg::CFG_W-1:0]  center_y_ff;
   logic signed [rpv_pkg::CFG_W-1:0]  push_x_ff;
   logic signed [rpv_pkg::CFG_W-1:0]  push_y_ff;
   logic signed [rpv_pkg::CFG_W-1:0]  spin_rate_ff;
   rpv_pkg::cfg_type                  cfg;

   rpv_pkg::cordic_data_type          beat_data  [rpv_pkg::CORDIC_STAGES+1];
   logic [rpv_pkg::CORDIC_STAGES:0]   beat_valid;
   logic [rpv_pkg::CORDIC_STAGES:0]   hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         push_x_ff    <= '0;
         push_y_ff    <= '0;
         spin_rate_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rpv_pkg::CSR_CENTER_X:  center_x_ff  <= csr_wdata;
            rpv_pkg::CSR_CENTER_Y:  center_y_ff  <= csr_wdata;
            rpv_pkg::CSR_PUSH_X:    push_x_ff    <= csr_wdata;
            rpv_pkg::CSR_PUSH_Y:    push_y_ff    <= csr_wdata;
            rpv_pkg::CSR_SPIN_RATE: spin_rate_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.rate = spin_rate_ff;
      cfg.dx   = rpv_pkg::D_W'(push_x_ff) - rpv_pkg::D_W'(center_x_ff);
      cfg.dy   = rpv_pkg::D_W'(push_y_ff) - rpv_pkg::D_W'(center_y_ff);
   end

   rpv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_time_s (req_time_s),
      .out_valid  (beat_valid[0]),
      .out_data   (beat_data[0]),
      .out_hold   (hold[0])
   );

   for (genvar i = 0; i < rpv_pkg::CORDIC_STAGES; i++) begin : g_cell
      rpv_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (rpv_pkg::stage_index(i)),
         .in_valid  (beat_valid[i]),
         .in_data   (beat_data[i]),
         .in_hold   (hold[i]),
         .out_valid (beat_valid[i+1]),
         .out_data  (beat_data[i+1]),
         .out_hold  (hold[i+1])
      );
   end

   rpv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rate      (spin_rate_ff),
      .in_valid  (beat_valid[rpv_pkg::CORDIC_STAGES]),
      .in_data   (beat_data[rpv_pkg::CORDIC_STAGES]),
      .in_hold   (hold[rpv_pkg::CORDIC_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_vel_x (rsp_vel_x),
      .rsp_vel_y (rsp_vel_y),
      .rsp_ok    (rsp_ok)
   );

   // no back-pressure from the result side means the input is never blocked
   `RPV_ASSERT_IMP(a_ready_when_free, clock, reset, !(rsp_valid && !rsp_ready), req_ready, "input blocked without output stall")

   `RPV_ASSERT_IMP(a_reject_zero, clock, reset, rsp_valid && !rsp_ok, rsp_vel_x == '0 && rsp_vel_y == '0, "rejected beat with nonzero velocity")

   // a held beat at the end of the cell chain keeps its contents
   `RPV_ASSERT_NXT(a_chain_hold, clock, reset, beat_valid[rpv_pkg::CORDIC_STAGES] && hold[rpv_pkg::CORDIC_STAGES], beat_valid[rpv_pkg::CORDIC_STAGES] && $stable(beat_data[rpv_pkg::CORDIC_STAGES]), "held cell beat changed")

endmodule

[sim/rotating_point_velocity_tb.sv]
// ---------------------------------------------------------------------------
// rotating_point_velocity_tb
// Drives time samples through the rotating point velocity block under several
// register settings, predicts each velocity beat in a scoreboard and compares
// every result beat field by field, with random stalls on both channels.
// ---------------------------------------------------------------------------
module rotating_point_velocity_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpv_pkg::*;

   localparam int          FRAC_W        = 16;
   localparam int          ROT_STAGES    = 16;
   localparam int          ROT_GUARD     = 6;
   localparam logic [63:0] TURNS_PER_RAD = 64'd683565276;
   localparam longint      ROT_GAIN_Q30  = 64'sd652032874;
   localparam int          PIPE_LATENCY  = 23;
   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          RANDOM_PHASES = 15;
   localparam int          PHASE_ITEMS   = 100;
   localparam int          LONG_HOLD     = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic                    ok;
   } velocity_type;

   class velocity_scoreboard;
      logic signed [CFG_W-1:0] regs [7];
      velocity_type            pending_velocities [$];
      int                      errors;

      // arctangent of 2^-i in turns, 32 fractional bits
      logic [31:0] atan_turns [ROT_STAGES] = '{
         32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
         32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
         32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
         32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
      };

      function new();
         foreach (regs[i]) regs[i] = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx <= CSR_SPIN_RATE) regs[idx] = val;
      endfunction

      function logic signed [VEL_W-1:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[VEL_W-1:0];
      endfunction

      function velocity_type predict_velocity(logic signed [TIME_W-1:0] t);
         longint       dx, dy, rate, ang, x, y, z, xs, ys, tmp;
         logic [63:0]  turn_prod;
         logic [31:0]  theta, rounded, r;
         quad_type     quad;
         int           i;
         velocity_type v;
         v = '0;
         if (t < 0) return v;
         dx   = longint'(regs[CSR_PUSH_X]) - longint'(regs[CSR_CENTER_X]);
         dy   = longint'(regs[CSR_PUSH_Y]) - longint'(regs[CSR_CENTER_Y]);
         rate = longint'(regs[CSR_SPIN_RATE]);
         ang  = (rate * longint'(t)) >>> FRAC_W;
         // wrap of the turn fraction is the reduction modulo two pi
         turn_prod = ang * TURNS_PER_RAD;
         theta     = turn_prod[FRAC_W +: 32];
         rounded   = theta + 32'h2000_0000;
         quad      = quad_type'(rounded[31:30]);
         r         = theta - {rounded[31:30], 30'd0};
         z         = longint'($signed(r));
         x = dx * (longint'(1) <<< ROT_GUARD);
         y = dy * (longint'(1) <<< ROT_GUARD);
         for (i = 0; i < ROT_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - longint'(atan_turns[i]);
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + longint'(atan_turns[i]);
            end
         end
         x = (x * ROT_GAIN_Q30 + (longint'(1) <<< (29 + ROT_GUARD))) >>> (30 + ROT_GUARD);
         y = (y * ROT_GAIN_Q30 + (longint'(1) <<< (29 + ROT_GUARD))) >>> (30 + ROT_GUARD);
         repeat (int'(quad)) begin
            tmp = x;
            x   = -y;
            y   = tmp;
         end
         v.vel_x = clamp32((-rate * y + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W);
         v.vel_y = clamp32((rate * x + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W);
         v.ok    = 1'b1;
         return v;
      endfunction

      function void note_sample(logic signed [TIME_W-1:0] t);
         pending_velocities.push_back(predict_velocity(t));
      endfunction

      function void check_velocity(logic signed [VEL_W-1:0] vx, logic signed [VEL_W-1:0] vy,
                                   logic ok);
         velocity_type e;
         if (pending_velocities.size() == 0) begin
            $display("%0t: unexpected result beat vel_x %0d vel_y %0d ok %0b",
                     $time, vx, vy, ok);
            errors++;
            return;
         end
         e = pending_velocities.pop_front();
         if (vx !== e.vel_x) begin
            $display("%0t: vel_x expected %0d, actual %0d", $time, e.vel_x, vx);
            errors++;
         end
         if (vy !== e.vel_y) begin
            $display("%0t: vel_y expected %0d, actual %0d", $time, e.vel_y, vy);
            errors++;
         end
         if (ok !== e.ok) begin
            $display("%0t: ok expected %0b, actual %0b", $time, e.ok, ok);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_velocities.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CFG_W-1:0]           csr_wdata;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [TIME_W-1:0]   req_time_s;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [VEL_W-1:0]    rsp_vel_x;
   logic signed [VEL_W-1:0]    rsp_vel_y;
   logic                       rsp_ok;

   velocity_scoreboard sb = new();
   int  cycle_count = 0;
   bit  rsp_quiet = 1'b0;
   bit  long_hold_req = 1'b0;
   int  gap_pct = 0;

   rotating_point_velocity i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_time_s (req_time_s),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_vel_x  (rsp_vel_x),
      .rsp_vel_y  (rsp_vel_y),
      .rsp_ok     (rsp_ok)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rotating_point_velocity_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_velocity(rsp_vel_x, rsp_vel_y, rsp_ok);
   end

   // result side: random stall bursts, one long hold on request
   initial begin
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic load_config(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                              input logic [CFG_W-1:0] cz, input logic [CFG_W-1:0] px,
                              input logic [CFG_W-1:0] py, input logic [CFG_W-1:0] pz,
                              input logic [CFG_W-1:0] rate);
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_CENTER_Y, cy);
      write_csr(CSR_CENTER_Z, cz);
      write_csr(CSR_PUSH_X, px);
      write_csr(CSR_PUSH_Y, py);
      write_csr(CSR_PUSH_Z, pz);
      write_csr(CSR_SPIN_RATE, rate);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] pick_coord();
      case ($urandom_range(0, 6))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'h000000;
         3:       return 24'($urandom_range(0, 32'h3FFFF)) - 24'h020000;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic signed [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 9))
         0:       return {1'b1, 31'($urandom)};
         1: begin
            case ($urandom_range(0, 4))
               0:       return 32'h0000_0000;
               1:       return 32'h0000_0001;
               2:       return 32'h7FFF_FFFF;
               3:       return 32'h8000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         2, 3:    return $urandom_range(0, 32'h000F_FFFF);
         default: return {1'b0, 31'($urandom)};
      endcase
   endfunction

   task automatic reconfigure_random();
      bit wrote;
      logic [CSR_IDX_W-1:0] idx;
      wrote = 1'b0;
      for (int k = 0; k <= CSR_SPIN_RATE; k++) begin
         if ($urandom_range(0, 1) == 1) begin
            idx = CSR_IDX_W'(k);
            write_csr(idx, pick_coord());
            wrote = 1'b1;
         end
      end
      if (!wrote || $urandom_range(0, 3) == 0) write_csr(CSR_UNMAPPED, 24'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(input logic signed [TIME_W-1:0] t);
      req_valid  <= 1'b1;
      req_time_s <= t;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(t);
   endtask

   task automatic send_with_gaps(input logic signed [TIME_W-1:0] t);
      if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      send_sample(t);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_valid  = 1'b0;
      req_time_s = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers still at reset: zero offset, zero rate
      send_sample(32'sh0000_0000);
      send_sample(32'shFFFF_FFFF);
      drain();

      // unit rate, unit offset along x: quarter turns and the 45 degree split
      load_config(24'h0, 24'h0, 24'h0, 24'h010000, 24'h0, 24'h0, 24'h010000);
      send_sample(32'sd0);
      send_sample(32'sd51472);
      send_sample(32'sd102944);
      send_sample(32'sd205887);
      send_sample(32'sd308831);
      send_sample(32'sd411775);
      drain();

      // widest offset and fastest positive rate, saturating results
      write_csr(CSR_UNMAPPED, 24'hFFFFFF);
      load_config(24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                  24'h7FFFFF);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh0000_0001);
      send_sample(32'sh0001_0000);
      send_sample(32'sh8000_0000);
      send_sample(32'shFFFF_FFFF);
      send_sample(32'sh4000_0000);
      drain();

      // most negative rate, offset pointing the other way
      load_config(24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h800000, 24'h800000, 24'h0, 24'h800000);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh1234_5678);
      send_sample(32'sh0000_0000);
      send_sample(32'sh7FFF_0000);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         reconfigure_random();
         rsp_quiet = (p >= RANDOM_PHASES - 2);
         gap_pct   = (rsp_quiet || p % 3 == 0) ? 0 : 25;
         // stall the result side long enough to back up into the input
         if (p == 2) long_hold_req = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_with_gaps(pick_time());
         drain();
      end

      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("rotating_point_velocity_tb: done, clean");
      end else begin
         $display("rotating_point_velocity_tb: done, errors");
      end
      $finish;
   end

endmodule
